FILE: hw/rtl/lgpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgpr_pkg: shared types and constants of the LED grid pixel renderer
// Beat payloads, lamp cell contents, tester results, control states and
// fixed widths used by the renderer and its cells.
// ----------------------------------------------------------------------------
package lgpr_pkg;

    localparam int COLOR_W    = 32;
    localparam int IDX_W      = 6;
    localparam int PX_W       = 11;
    localparam int DIM_W      = 12;   // frame size registers and spacings
    localparam int RAD_W      = 11;   // radius is at most half a frame width
    localparam int R2_W       = 2 * RAD_W;
    localparam int SQ_W       = 2 * DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Reciprocal shift for dividing a 12-bit size by a divisor up to 64
    localparam int DIV_SHIFT  = 18;
    localparam int MUL_W      = DIM_W + DIV_SHIFT + 1;

    // Command codes
    localparam logic CMD_SET   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_COLOR    = 3'd3;

    // Register reset values
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 12'd480;
    localparam logic [COLOR_W-1:0] BG_RESET     = 32'hFF1E_2823;
    localparam logic [COLOR_W-1:0] OFF_RESET    = 32'h0000_0000;

    typedef struct packed {
        logic               command;
        logic [IDX_W-1:0]   led_index;
        logic               led_on;
        logic [COLOR_W-1:0] led_color;
        logic [PX_W-1:0]    pixel_x;
        logic [PX_W-1:0]    pixel_y;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               in_frame;
    } out_item_t;

    typedef struct packed {
        logic               lit;
        logic [COLOR_W-1:0] color;
    } lamp_t;

    typedef struct packed {
        logic  busy;    // an item is still inside the tester
        logic  valid;   // result below belongs to one lamp
        logic  hit;     // pixel lies inside that lamp's disc
        lamp_t lamp;
    } hit_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SQUARE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

FILE: hw/rtl/lgpr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgpr_cell: one lamp cell of the rotating store
// Holds one LED's on flag and colour; loads from a set beat or takes the
// contents of its neighbor when the ring advances.
// ----------------------------------------------------------------------------
module lgpr_cell
    import lgpr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  logic  shift,
    input  lamp_t load_data,
    input  lamp_t shift_in,
    output lamp_t q
);

    logic               lit_reg;
    logic               lit_next;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;

    always_comb
    begin
        lit_next   = lit_reg;
        color_next = color_reg;
        if (load)
        begin
            lit_next   = load_data.lit;
            color_next = load_data.color;
        end
        else if (shift)
        begin
            lit_next   = shift_in.lit;
            color_next = shift_in.color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lit_reg <= 1'b0;
        else
            lit_reg <= lit_next;
    end

    // Colour only counts once the flag has been written with it
    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
    end

    assign q.lit   = lit_reg;
    assign q.color = color_reg;

endmodule

FILE: hw/rtl/lgpr_disc_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgpr_disc_test: pipelined point-in-disc tester
// Takes one lamp centre per cycle, squares the offsets to the pixel in a
// registered stage and compares the sum with the squared radius.
// ----------------------------------------------------------------------------
module lgpr_disc_test
    import lgpr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            feed_valid,
    input  logic [PX_W-1:0] px,
    input  logic [PX_W-1:0] py,
    input  logic [DIM_W-1:0] cx,
    input  logic [DIM_W-1:0] cy,
    input  lamp_t           lamp,
    input  logic [R2_W-1:0] r2,
    output hit_t            result
);

    logic signed [DIM_W:0] dx;
    logic signed [DIM_W:0] dy;
    logic [DIM_W-1:0]      adx_next;
    logic [DIM_W-1:0]      ady_next;

    logic                  v1_reg;
    logic [DIM_W-1:0]      adx_reg;
    logic [DIM_W-1:0]      ady_reg;
    lamp_t                 lamp1_reg;

    logic                  v2_reg;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;
    lamp_t                 lamp2_reg;
    logic [SQ_W:0]         dist2;

    // Absolute offsets from the lamp centre
    always_comb
    begin
        dx       = $signed({2'b00, px}) - $signed({1'b0, cx});
        dy       = $signed({2'b00, py}) - $signed({1'b0, cy});
        adx_next = dx[DIM_W] ? DIM_W'(-dx) : DIM_W'(dx);
        ady_next = dy[DIM_W] ? DIM_W'(-dy) : DIM_W'(dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= feed_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg   <= adx_next;
        ady_reg   <= ady_next;
        lamp1_reg <= lamp;
        sqx_reg   <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
        sqy_reg   <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
        lamp2_reg <= lamp1_reg;
    end

    assign dist2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    assign result.busy  = v1_reg | v2_reg;
    assign result.valid = v2_reg;
    assign result.hit   = dist2 <= (SQ_W + 1)'(r2);
    assign result.lamp  = lamp2_reg;

endmodule

FILE: hw/rtl/led_grid_pixel_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_grid_pixel_renderer: LED grid pixel renderer, top level
// Keeps the state of a grid of round LEDs and answers pixel colour queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready) carry either a set command, which stores
//   the on flag and colour of one LED, or a query for one pixel coordinate.
//   Each query returns one output beat (out_valid/out_ready) with the ARGB
//   colour and an in-frame flag; a set returns nothing.
//   The LED state lives in a ring of lamp cells. A query first derives the
//   spacings and radius from the frame size and squares the radius, then
//   rotates the ring once so that every lamp passes the disc tester, one
//   lamp a cycle, then drains the tester. A set is stored in its cell and
//   leaves the block idle, ready for the next beat.
//   The result sits in an output register: while it waits for out_ready the
//   block takes set beats and starts the next query, and it stalls only when
//   a second result is ready before the first is taken.
//   Reset switches every LED off and loads the register reset values. The
//   configuration port (cfg_we, cfg_index, cfg_data) writes one register per
//   cycle and is meant to be used while the block is idle.
// ----------------------------------------------------------------------------
module led_grid_pixel_renderer
    import lgpr_pkg::*;
#(
    parameter int GRID_ROWS     = 8,
    parameter int GRID_COLS     = 8,
    parameter int MAX_FRAME_DIM = 2048
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LAMP_COUNT  = GRID_ROWS * GRID_COLS;
    localparam int STORE_DEPTH = 1 << IDX_W;
    // Lamps numbered beyond the index range have no cell and stay dark
    localparam int NCELL       = (LAMP_COUNT < STORE_DEPTH) ? LAMP_COUNT : STORE_DEPTH;
    localparam int STEP_W      = (LAMP_COUNT > 1) ? $clog2(LAMP_COUNT) : 1;
    localparam int COL_W       = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LAMP_COUNT - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(GRID_COLS - 1);

    // Rounded-up reciprocals: exact floor division of any 12-bit size
    localparam int unsigned RECIP_COL = ((1 << DIV_SHIFT) + GRID_COLS - 1) / GRID_COLS;
    localparam int unsigned RECIP_ROW = ((1 << DIV_SHIFT) + GRID_ROWS - 1) / GRID_ROWS;
    localparam int unsigned RECIP_RAD = ((1 << DIV_SHIFT) + 2 * GRID_COLS - 1)
                                        / (2 * GRID_COLS);

    // Configuration registers
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [COLOR_W-1:0] off_reg;

    // Control
    state_t             state_reg;
    state_t             state_next;
    logic               in_ready_c;
    logic               ring_shift;
    logic               feed_valid;
    logic               out_load;
    logic               set_fire;
    logic               query_fire;

    // Geometry and scan position
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [MUL_W-1:0]   sx_prod;
    logic [MUL_W-1:0]   sy_prod;
    logic [MUL_W-1:0]   r_prod;
    logic [DIM_W-1:0]   sx_reg;
    logic [DIM_W-1:0]   sy_reg;
    logic [RAD_W-1:0]   r_reg;
    logic [R2_W-1:0]    r2_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [COL_W-1:0]   col_reg;
    logic [DIM_W-1:0]   cx_reg;
    logic [DIM_W-1:0]   cy_reg;
    logic               step_in_store;

    // Query payload and result
    logic [PX_W-1:0]    px_reg;
    logic [PX_W-1:0]    py_reg;
    logic               in_frame_reg;
    logic               in_frame_c;
    logic [COLOR_W-1:0] colour_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    lamp_t              ring_q [NCELL];
    lamp_t              lamp_new;
    lamp_t              lamp_feed;
    hit_t               hit;

    assign set_fire   = in_valid && in_ready_c && (in_data.command == CMD_SET);
    assign query_fire = in_valid && in_ready_c && (in_data.command == CMD_QUERY);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            bg_reg     <= BG_RESET;
            off_reg    <= OFF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                CFG_BACKGROUND:   bg_reg     <= cfg_data[COLOR_W-1:0];
                CFG_OFF_COLOR:    off_reg    <= cfg_data[COLOR_W-1:0];
                default:          ;  // unused index: drop the write
            endcase
        end
    end

    // Saturate the frame size at the largest supported dimension
    always_comb
    begin
        w_eff = width_reg;
        h_eff = height_reg;
        if (32'(width_reg) > 32'(MAX_FRAME_DIM))
            w_eff = DIM_W'(MAX_FRAME_DIM);
        if (32'(height_reg) > 32'(MAX_FRAME_DIM))
            h_eff = DIM_W'(MAX_FRAME_DIM);
        in_frame_c = ({1'b0, in_data.pixel_x} < w_eff)
                  && ({1'b0, in_data.pixel_y} < h_eff);
    end

    // ------------------------------------------------------------------
    // Lamp ring: cell 0 is the head seen by the tester; one full turn per
    // query brings every cell back to its home place.
    // ------------------------------------------------------------------
    assign lamp_new.lit   = in_data.led_on;
    assign lamp_new.color = in_data.led_color;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        lgpr_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (set_fire && (in_data.led_index == IDX_W'(k))),
            .shift     (ring_shift),
            .load_data (lamp_new),
            .shift_in  (ring_q[(k + 1) % NCELL]),
            .q         (ring_q[k])
        );
    end

    assign step_in_store   = {1'b0, step_reg} < (STEP_W + 1)'(NCELL);
    assign lamp_feed.lit   = step_in_store & ring_q[0].lit;
    assign lamp_feed.color = ring_q[0].color;

    lgpr_disc_test u_disc_test
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed_valid (feed_valid),
        .px         (px_reg),
        .py         (py_reg),
        .cx         (cx_reg),
        .cy         (cy_reg),
        .lamp       (lamp_feed),
        .r2         (r2_reg),
        .result     (hit)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready_c = 1'b0;
        ring_shift = 1'b0;
        feed_valid = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready_c = 1'b1;
                if (in_valid && (in_data.command == CMD_QUERY))
                    state_next = ST_SETUP;
            end
            ST_SETUP:
                state_next = ST_SQUARE;
            ST_SQUARE:
                state_next = ST_RUN;
            ST_RUN:
            begin
                feed_valid = 1'b1;
                ring_shift = step_in_store;
                if (step_reg == LAST_STEP)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                if (!hit.busy)
                    state_next = ST_FINISH;
            ST_FINISH:
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Geometry: spacings and radius by reciprocal multiply, then r squared
    // ------------------------------------------------------------------
    assign sx_prod = MUL_W'(w_eff) * MUL_W'(RECIP_COL);
    assign sy_prod = MUL_W'(h_eff) * MUL_W'(RECIP_ROW);
    assign r_prod  = MUL_W'(w_eff) * MUL_W'(RECIP_RAD);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
        begin
            sx_reg <= sx_prod[DIV_SHIFT +: DIM_W];
            sy_reg <= sy_prod[DIV_SHIFT +: DIM_W];
            r_reg  <= r_prod[DIV_SHIFT +: RAD_W];
        end
        if (state_reg == ST_SQUARE)
            r2_reg <= R2_W'(r_reg) * R2_W'(r_reg);
    end

    // Scan position: advance the lamp centre one column per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            col_reg  <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
        end
        else if (state_reg == ST_SQUARE)
        begin
            step_reg <= '0;
            col_reg  <= '0;
            cx_reg   <= sx_reg >> 1;
            cy_reg   <= sy_reg >> 1;
        end
        else if (state_reg == ST_RUN)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (col_reg == LAST_COL)
            begin
                col_reg <= '0;
                cx_reg  <= sx_reg >> 1;
                cy_reg  <= cy_reg + sy_reg;
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
                cx_reg  <= cx_reg + sx_reg;
            end
        end
    end

    // Query payload and running colour: the last disc hit wins
    always_ff @(posedge clk)
    begin
        if (query_fire)
        begin
            px_reg       <= in_data.pixel_x;
            py_reg       <= in_data.pixel_y;
            in_frame_reg <= in_frame_c;
            colour_reg   <= bg_reg;
        end
        else if (hit.valid && hit.hit)
        begin
            colour_reg <= hit.lamp.lit ? hit.lamp.color : off_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.pixel_color <= in_frame_reg ? colour_reg : bg_reg;
            out_data_reg.in_frame    <= in_frame_reg;
        end
    end

    assign in_ready  = in_ready_c;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        hit.valid |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("tester result outside a scan");

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        query_fire |=> (state_reg == ST_SETUP))
        else $error("accepted query did not start the geometry setup");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    a_outside_is_bg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.in_frame) |-> (out_data.pixel_color == bg_reg))
        else $error("out-of-frame pixel not background");

endmodule
